// ===== src/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg: shared constants and code table for the NTC converter
// Holds the non-decreasing ADC code table (one entry per degree from -30 to 125)
// and the widths and fixed values that the pipeline modules share.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int ADC_BITS      = 10;
  localparam int TABLE_ENTRIES = 156;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int TEMP_W        = 12;
  localparam int OFFSET_W      = 10;
  localparam int FRAC_W        = 4;
  localparam int FRAC_STEPS    = 10;
  localparam int PROD_W        = ADC_BITS + FRAC_W;
  localparam int SUM_W         = TEMP_W + 1;

  localparam int BASE_TENTHS   = -300;
  localparam int OOR_TEMP      = -274;
  localparam int OFFSET_RESET  = -33;

  localparam logic [ADC_BITS-1:0] CODE_ROM [TABLE_ENTRIES] = '{
    10'd50,  10'd53,  10'd57,  10'd60,  10'd64,  10'd68,  10'd72,  10'd76,  10'd80,  10'd85,
    10'd90,  10'd95,  10'd100, 10'd105, 10'd111, 10'd117, 10'd123, 10'd129, 10'd136, 10'd143,
    10'd150, 10'd157, 10'd165, 10'd172, 10'd181, 10'd189, 10'd197, 10'd206, 10'd215, 10'd224,
    10'd234,
    10'd243, 10'd253, 10'd263, 10'd273, 10'd284, 10'd294, 10'd305, 10'd316, 10'd327, 10'd338,
    10'd349, 10'd361, 10'd372, 10'd384, 10'd395, 10'd407, 10'd419, 10'd430, 10'd442, 10'd454,
    10'd465, 10'd477, 10'd489, 10'd500, 10'd512, 10'd523, 10'd535, 10'd546, 10'd557, 10'd569,
    10'd580, 10'd590, 10'd601, 10'd612, 10'd622, 10'd632, 10'd642, 10'd652, 10'd662, 10'd672,
    10'd681, 10'd690, 10'd700, 10'd708, 10'd717, 10'd726, 10'd734, 10'd742, 10'd750, 10'd758,
    10'd765, 10'd773, 10'd780, 10'd787, 10'd794, 10'd801, 10'd807, 10'd814, 10'd820, 10'd826,
    10'd832, 10'd837, 10'd843, 10'd848, 10'd854, 10'd859, 10'd864, 10'd868, 10'd873, 10'd877,
    10'd882, 10'd886, 10'd890, 10'd894, 10'd898, 10'd902, 10'd905, 10'd909, 10'd912, 10'd916,
    10'd919, 10'd922, 10'd925, 10'd928, 10'd931, 10'd934, 10'd936, 10'd939, 10'd941, 10'd944,
    10'd946, 10'd948, 10'd951, 10'd953, 10'd955, 10'd957, 10'd959, 10'd961, 10'd963, 10'd966,
    10'd966, 10'd968, 10'd969, 10'd971, 10'd972, 10'd974, 10'd975, 10'd977, 10'd978, 10'd979,
    10'd980, 10'd982, 10'd983, 10'd984, 10'd985, 10'd986, 10'd987, 10'd988, 10'd989, 10'd990,
    10'd991, 10'd992, 10'd993, 10'd994, 10'd995
  };

  localparam logic [ADC_BITS-1:0] CODE_LO = CODE_ROM[0];
  localparam logic [ADC_BITS-1:0] CODE_HI = CODE_ROM[TABLE_ENTRIES-1];

  // Indexes past the end of the table read as zero.
  function automatic logic [ADC_BITS-1:0] rom_code(input logic [IDX_BITS-1:0] idx);
    logic [ADC_BITS-1:0] val;
    val = '0;
    if (int'(idx) < TABLE_ENTRIES) begin
      val = CODE_ROM[idx];
    end
    return val;
  endfunction

endpackage

// ===== src/ntc_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature: NTC divider ADC code to temperature in tenths
// Pipeline: 8 search stages, one per table index bit, then 3 interpolation
// stages between input accept and output valid.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output. Reset (synchronous) empties the pipeline and sets
// the calibration offset to -3.3 degrees.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ntc_pkg::ADC_BITS-1:0]         adc_code,
  input  logic                                 cfg_wr_en,
  input  logic [ntc_pkg::OFFSET_W-1:0]         cfg_wr_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0]    temp_tenths,
  output logic                                 range_error
);
  import ntc_pkg::*;

  logic signed [OFFSET_W-1:0] temp_offset;
  logic                       en;
  logic                       srch_vld;
  logic [ADC_BITS-1:0]        srch_code;
  logic [IDX_BITS-1:0]        srch_idx;
  logic                       srch_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_offset <= OFFSET_W'(OFFSET_RESET);
    end else if (cfg_wr_en) begin
      temp_offset <= cfg_wr_data;
    end
  end

  // Advance every stage unless a finished item is still waiting.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ntc_search u_search (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (in_valid),
    .in_code  (adc_code),
    .out_vld  (srch_vld),
    .out_code (srch_code),
    .out_idx  (srch_idx),
    .out_err  (srch_err)
  );

  ntc_interp u_interp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (srch_vld),
    .in_code  (srch_code),
    .in_idx   (srch_idx),
    .in_err   (srch_err),
    .offset   (temp_offset),
    .out_vld  (out_valid),
    .out_temp (temp_tenths),
    .out_err  (range_error)
  );

  a_oor_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> temp_tenths == TEMP_W'(OOR_TEMP))
    else $error("out-of-range item without the fixed reading");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temp_tenths) && $stable(range_error))
    else $error("stalled item changed");

endmodule

// ===== src/ntc_search.sv =====
// ----------------------------------------------------------------------------
// ntc_search: pipelined binary search over the code table
// One stage per index bit, MSB first; each stage decides one bit of the
// greatest index whose table code does not exceed the ADC code.
// ----------------------------------------------------------------------------
module ntc_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [ntc_pkg::ADC_BITS-1:0]  in_code,
  output logic                          out_vld,
  output logic [ntc_pkg::ADC_BITS-1:0]  out_code,
  output logic [ntc_pkg::IDX_BITS-1:0]  out_idx,
  output logic                          out_err
);
  import ntc_pkg::*;

  logic                vld_q  [IDX_BITS];
  logic                err_q  [IDX_BITS];
  logic [ADC_BITS-1:0] code_q [IDX_BITS];
  logic [IDX_BITS-1:0] idx_q  [IDX_BITS];

  for (genvar s = 0; s < IDX_BITS; s++) begin : g_stage
    localparam logic [IDX_BITS-1:0] STEP = IDX_BITS'(1) << (IDX_BITS - 1 - s);

    logic                prev_vld;
    logic                prev_err;
    logic [ADC_BITS-1:0] prev_code;
    logic [IDX_BITS-1:0] prev_idx;
    logic [IDX_BITS-1:0] cand;
    logic                take;

    if (s == 0) begin : g_first
      assign prev_vld  = in_vld;
      assign prev_code = in_code;
      assign prev_idx  = '0;
      assign prev_err  = (in_code < CODE_LO) || (in_code > CODE_HI);
    end else begin : g_next
      assign prev_vld  = vld_q[s-1];
      assign prev_code = code_q[s-1];
      assign prev_idx  = idx_q[s-1];
      assign prev_err  = err_q[s-1];
    end

    assign cand = prev_idx | STEP;
    assign take = ({1'b0, cand} < (IDX_BITS+1)'(TABLE_ENTRIES)) &&
                  (rom_code(cand) <= prev_code);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        code_q[s] <= prev_code;
        err_q[s]  <= prev_err;
        idx_q[s]  <= take ? cand : prev_idx;
      end
    end
  end

  assign out_vld  = vld_q[IDX_BITS-1];
  assign out_code = code_q[IDX_BITS-1];
  assign out_idx  = idx_q[IDX_BITS-1];
  assign out_err  = err_q[IDX_BITS-1];

  // An in-range item must land on an entry at or below its code.
  a_idx_le_code: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_err |-> rom_code(out_idx) <= out_code)
    else $error("search index points above the code");

  // The next entry, where it exists, must lie above the code.
  a_idx_greatest: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_err && (int'(out_idx) < TABLE_ENTRIES - 1) |->
      rom_code(out_idx + IDX_BITS'(1)) > out_code)
    else $error("search index is not the greatest match");

endmodule

// ===== src/ntc_interp.sv =====
// ----------------------------------------------------------------------------
// ntc_interp: interpolation to tenths and offset addition
// Three stages: interval position and span, tenths digit by parallel
// compares against multiples of the span, then scaling, offset and output.
// ----------------------------------------------------------------------------
module ntc_interp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [ntc_pkg::ADC_BITS-1:0]         in_code,
  input  logic [ntc_pkg::IDX_BITS-1:0]         in_idx,
  input  logic                                 in_err,
  input  logic signed [ntc_pkg::OFFSET_W-1:0]  offset,
  output logic                                 out_vld,
  output logic signed [ntc_pkg::TEMP_W-1:0]    out_temp,
  output logic                                 out_err
);
  import ntc_pkg::*;

  // Stage 1: position inside the interval and interval width
  logic                vld1;
  logic                err1;
  logic                last1;
  logic [IDX_BITS-1:0] idx1;
  logic [ADC_BITS-1:0] pos1;
  logic [ADC_BITS-1:0] span1;

  // Stage 2: tenths digit
  logic                vld2;
  logic                err2;
  logic [IDX_BITS-1:0] idx2;
  logic [FRAC_W-1:0]   frac2;
  logic [FRAC_W-1:0]   frac_next;

  logic [PROD_W-1:0]   pos_x10;
  logic [SUM_W-1:0]    idx_x10;
  logic [SUM_W-1:0]    sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err1  <= in_err;
      idx1  <= in_idx;
      last1 <= (int'(in_idx) == TABLE_ENTRIES - 1);
      pos1  <= in_code - rom_code(in_idx);
      span1 <= rom_code(in_idx + IDX_BITS'(1)) - rom_code(in_idx);
    end
  end

  // Largest k with k*span <= 10*pos; pos < span keeps it below ten.
  assign pos_x10 = PROD_W'(pos1) * PROD_W'(FRAC_STEPS);

  always_comb begin
    frac_next = '0;
    for (int k = 1; k < FRAC_STEPS; k++) begin
      if (PROD_W'(k) * PROD_W'(span1) <= pos_x10) begin
        frac_next = FRAC_W'(k);
      end
    end
    if (last1 || span1 == '0) begin
      frac_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err2  <= err1;
      idx2  <= idx1;
      frac2 <= frac_next;
    end
  end

  // Stage 3: degrees to tenths, add table base, digit and offset
  assign idx_x10  = SUM_W'(idx2) * SUM_W'(FRAC_STEPS);
  assign sum_next = idx_x10 + SUM_W'(BASE_TENTHS) + SUM_W'(frac2) + SUM_W'(offset);

  always_ff @(posedge clk) begin
    if (en) begin
      out_err  <= err2;
      out_temp <= err2 ? TEMP_W'(OOR_TEMP) : sum_next[TEMP_W-1:0];
    end
  end

  a_frac_digit: assert property (@(posedge clk) disable iff (rst)
    vld2 && !err2 |-> frac2 < FRAC_W'(FRAC_STEPS))
    else $error("interpolation digit out of range");

  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld1 && !err1 && !last1 |-> span1 != '0 && pos1 < span1)
    else $error("interval position outside its span");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the NTC ADC code to temperature converter
// Sends ADC codes over the valid/ready input channel and checks every reading
// against typed values or a table-search and interpolation predictor. It starts
// with a short directed table (span edges, duplicated code, bit patterns), then
// runs random phases under several calibration offsets, extremes included.
// The sender works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import ntc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASE_ITEMS    = 222;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     err;
  } reading_t;

  typedef struct {
    logic [ADC_BITS-1:0] code;
    bit                  typed;
    int                  temp;
    bit                  err;
  } dir_row_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       in_valid    = 1'b0;
  logic [ADC_BITS-1:0]        adc_code    = '0;
  logic                       cfg_wr_en   = 1'b0;
  logic [OFFSET_W-1:0]        cfg_wr_data = '0;
  logic                       out_ready   = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [TEMP_W-1:0]   temp_tenths;
  logic                       range_error;

  reading_t expected_readings[$];
  dir_row_t dir_rows[$];
  int       offset_now;
  int       burst_left   = 0;
  int       n_sent       = 0;
  int       n_checked    = 0;
  int       n_oor        = 0;
  int       n_settings   = 0;
  int       mismatches   = 0;
  int       idle_cycles  = 0;
  rx_mode_t rx_mode      = RX_ALWAYS;
  int       rx_left      = 0;
  logic [7:0] rx_tick    = '0;

  ntc_adc_to_temperature dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adc_code    (adc_code),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .temp_tenths (temp_tenths),
    .range_error (range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Greatest table index at or below the code, then tenths towards the next entry.
  function automatic reading_t predict_reading(logic [ADC_BITS-1:0] code, int offset);
    reading_t r;
    int       idx;
    int       span;
    int       pos;
    int       frac;
    idx   = 0;
    frac  = 0;
    r.err = 1'b0;
    if (code < CODE_LO || code > CODE_HI) begin
      r.err  = 1'b1;
      r.temp = TEMP_W'(OOR_TEMP);
    end else begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (CODE_ROM[k] <= code) idx = k;
      end
      if (idx + 1 < TABLE_ENTRIES) begin
        span = int'(CODE_ROM[idx+1]) - int'(CODE_ROM[idx]);
        pos  = int'(code) - int'(CODE_ROM[idx]);
        if (span != 0) frac = (pos * 100 / span) / 10;
      end
      r.temp = TEMP_W'(BASE_TENTHS + idx * 10 + frac + offset);
    end
    return r;
  endfunction

  function automatic logic [ADC_BITS-1:0] random_code();
    int pick;
    int c;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: c = $urandom_range(0, 1023);
      2: c = $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(985, 1023);
      3, 4, 5: c = int'(CODE_ROM[$urandom_range(0, TABLE_ENTRIES-1)])
                   + int'($urandom_range(0, 4)) - 2;
      default: c = $urandom_range(CODE_LO, CODE_HI);
    endcase
    return c[ADC_BITS-1:0];
  endfunction

  function automatic void add_row(int code, bit typed, int temp, bit err);
    dir_row_t r;
    r.code  = code[ADC_BITS-1:0];
    r.typed = typed;
    r.temp  = temp;
    r.err   = err;
    dir_rows.push_back(r);
  endfunction

  // Hold the item until accepted, then gap at the end of a burst.
  task automatic send_item(logic [ADC_BITS-1:0] code, reading_t want);
    int gap;
    in_valid <= 1'b1;
    adc_code <= code;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(want);
    n_sent++;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 240)
                                               : $urandom_range(0, 16);
      in_valid  <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic set_offset(logic signed [OFFSET_W-1:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    offset_now   = v;
    n_settings++;
  endtask

  task automatic run_phase(int n);
    logic [ADC_BITS-1:0] code;
    send_item(CODE_LO, predict_reading(CODE_LO, offset_now));
    send_item(CODE_HI, predict_reading(CODE_HI, offset_now));
    send_item(10'd966, predict_reading(10'd966, offset_now));
    for (int i = 0; i < n; i++) begin
      code = random_code();
      send_item(code, predict_reading(code, offset_now));
      // now and then let the pipeline empty completely
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  // Receiver: ready pattern changes after a randomly drawn run length.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1'b1;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= (rx_tick[2:0] == 3'd0);
      default:   out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb_top: unexpected reading at %0t: temp %0d err %0b",
                   $time, temp_tenths, range_error);
      end else begin
        want = expected_readings.pop_front();
        n_checked++;
        if (range_error) n_oor++;
        if (temp_tenths !== want.temp || range_error !== want.err) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb_top: mismatch at %0t: expected temp %0d err %0b, got temp %0d err %0b",
                     $time, want.temp, want.err, temp_tenths, range_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reading_t want;
    //       code  typed  temp  err
    add_row(    0, 1,    -274, 1);  // all bits low, below span
    add_row(   49, 1,    -274, 1);
    add_row(   50, 1,    -333, 0);  // first entry, reset offset
    add_row(   51, 0,       0, 0);
    add_row(   52, 0,       0, 0);
    add_row(   53, 0,       0, 0);
    add_row(  234, 1,     -33, 0);  // zero degrees
    add_row(  965, 0,       0, 0);
    add_row(  966, 1,     977, 0);  // duplicated entry takes the higher index
    add_row(  967, 0,       0, 0);
    add_row(  994, 0,       0, 0);
    add_row(  995, 1,    1217, 0);  // last entry, nothing to interpolate
    add_row(  996, 1,    -274, 1);
    add_row( 1023, 1,    -274, 1);  // all bits high, above span
    add_row(  512, 0,       0, 0);
    add_row(  511, 0,       0, 0);
    add_row(  682, 0,       0, 0);
    add_row(  341, 0,       0, 0);
    add_row(  700, 0,       0, 0);

    offset_now = OFFSET_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        want.temp = TEMP_W'(dir_rows[i].temp);
        want.err  = dir_rows[i].err;
      end else begin
        want = predict_reading(dir_rows[i].code, offset_now);
      end
      send_item(dir_rows[i].code, want);
    end

    set_offset(-10'sd512);
    run_phase(PHASE_ITEMS);
    set_offset(10'sd511);
    run_phase(PHASE_ITEMS);
    set_offset(10'sd0);
    run_phase(PHASE_ITEMS);
    set_offset(-10'sd1);
    run_phase(PHASE_ITEMS);
    set_offset(10'sd1);
    run_phase(PHASE_ITEMS);
    repeat (3) begin
      set_offset(OFFSET_W'($urandom_range(0, 1023)));
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d codes under %0d offset settings, %0d readings checked (%0d out of range)",
             n_sent, n_settings + 1, n_checked, n_oor);
    $display("tb_top: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ntc_pkg.sv
src/ntc_search.sv
src/ntc_interp.sv
src/ntc_adc_to_temperature.sv
test/tb_top.sv
